/* sv/wsr_pkg.sv */
// Shared constants and controller/datapath command and status types for the resampler.
`default_nettype none
package wsr_pkg;

  localparam int HALF_TAPS_DEF     = 32;
  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int COUNT_BITS_DEF    = 24;
  localparam int MAX_RESULTS       = 40;

  localparam int POS_W    = 40;
  localparam int IPOS_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 21;
  localparam int RATIO_W  = 17;
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 18;
  localparam int WIDX_W   = 7;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO = 2'd1;

  localparam logic REQ_WEIGHT = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 21'd65536;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd65536;

  typedef struct packed {
    logic wr_weight;
    logic wr_sample;
    logic calc_total;
    logic setup;
    logic interp;
    logic do_round;
    logic emit;
    logic last;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic norm_go;
    logic flush_go;
    logic more_after;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* sv/wsr_if.sv */
// Handshake channel interfaces for sample input, result output and register writes.
`default_nettype none
interface wsr_in_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [6:0]           weight_index;
  logic signed [17:0]   weight_value;
  logic signed [15:0]   left_in;
  logic signed [15:0]   right_in;
  logic                 final_sample;

  modport source (output valid, req_type, weight_index, weight_value, left_in, right_in,
                  final_sample, input ready);
  modport sink   (input valid, req_type, weight_index, weight_value, left_in, right_in,
                  final_sample, output ready);
endinterface

interface wsr_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   left_out;
  logic signed [15:0]   right_out;
  logic                 stream_end;

  modport source (output valid, left_out, right_out, stream_end, input ready);
  modport sink   (input valid, left_out, right_out, stream_end, output ready);
endinterface

interface wsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [20:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/wsr_mod.sv */
// Ring-address remainder unit: reduces a window start position modulo the history depth.
`default_nettype none
module wsr_mod #(
  parameter int W   = 26,
  parameter int DIV = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [W-1:0]             num_i,
  output logic                          busy_o,
  output logic [$clog2(DIV)-1:0]        rem_o
);
  localparam int AW = $clog2(DIV);
  localparam int SH = W + AW;
  localparam int KW = W + 2;
  localparam int PW = W + KW;
  // The reciprocal of the depth is rounded up and scaled by 2^SH, which makes the
  // quotient exact for every W-bit numerator.
  localparam longint unsigned RecipL = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [KW-1:0]   Recip  = KW'(RecipL);
  localparam logic [AW:0]     DivW   = (AW + 1)'(DIV);

  logic [1:0]    cnt_q, cnt_d;
  logic [W-1:0]  num_q, quo_q, quo_d, back;
  logic [PW-1:0] prod;
  logic [AW-1:0] r_q, r_d;

  // The quotient is registered first; the remainder is then formed from it and registered.
  always_comb begin
    prod  = PW'(num_q) * PW'(Recip);
    quo_d = W'(prod >> SH);
    back  = quo_q * W'(DIV);
    r_d   = AW'(num_q - back);
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = 2'd2;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      num_q <= '0;
      quo_q <= '0;
      r_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (start_i) begin
        num_q <= num_i;
      end
      if (cnt_q == 2'd2) begin
        quo_q <= quo_d;
      end
      if (cnt_q == 2'd1) begin
        r_q <= r_d;
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = r_q;

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> ((AW + 1)'(r_q) < DivW))
    else $error("remainder not below the history depth");
`endif

endmodule
`default_nettype wire

/* sv/wsr_datapath.sv */
// Datapath: weight and history memories, tap MAC pipeline, interpolation and stream counters.
`default_nettype none
module wsr_datapath #(
  parameter int HALF_TAPS     = 32,
  parameter int HISTORY_DEPTH = 128,
  parameter int COUNT_BITS    = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire wsr_pkg::cmd_t              cmd_i,
  output wsr_pkg::status_t                st_o,
  input  wire logic [6:0]                 weight_index_i,
  input  wire logic signed [17:0]         weight_value_i,
  input  wire logic signed [15:0]         left_in_i,
  input  wire logic signed [15:0]         right_in_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [20:0]                cfg_data_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic signed [15:0]              left_out_o,
  output logic signed [15:0]              right_out_o,
  output logic                            stream_end_o
);
  import wsr_pkg::*;

  localparam int TAPS  = 2 * HALF_TAPS + 1;
  localparam int WIW   = $clog2(TAPS);
  localparam int TCW   = $clog2(TAPS + 1);
  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int CW    = ((COUNT_BITS > IPOS_W) ? COUNT_BITS : IPOS_W) + 2;
  localparam int ACC_W = PROD_W + $clog2(TAPS);
  localparam int DL_W  = ACC_W + 1 + FRAC_W + 1;
  localparam int SW    = ACC_W + 19;
  localparam int TOT_W = COUNT_BITS + 1;
  localparam int MUL_W = COUNT_BITS + RATIO_W;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [CW-1:0] HalfW = CW'(HALF_TAPS);

  // Stream state and registers.
  logic [STEP_W-1:0]     step_q;
  logic [RATIO_W-1:0]    ratio_q;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [COUNT_BITS-1:0] seen_q, sent_q;
  logic [AW-1:0]         wp_q, wp_nx;
  logic [TOT_W-1:0]      total_q;
  logic [MUL_W-1:0]      tot_prod;
  logic [POS_W:0]        pos_sum;

  // Memories.
  logic signed [WEIGHT_W-1:0] wtab_mem [TAPS];
  logic [2*SAMPLE_W-1:0]      hist_mem [HISTORY_DEPTH];
  logic                       hist_we;

  // Window setup.
  logic [CW-1:0]  ipos_x, seen_x, d1, d2, hi, k_full;
  logic [WIW-1:0] widx0;
  logic [TCW-1:0] rem_init;
  logic           mod_busy;
  logic [AW-1:0]  mod_rem;

  // Tap pipeline.
  logic [TCW-1:0] rem_q;
  logic           first_q, s1_v_q, s1_first_q, s2_v_q;
  logic           issue;
  logic [AW-1:0]  raddr_q, raddr_cur, raddr_nx;
  logic [WIW-1:0] widx_q;
  logic [2*SAMPLE_W-1:0]      hq_q, prev_q;
  logic signed [WEIGHT_W-1:0] wq_q;
  logic signed [PROD_W-1:0]   pl0_q, pr0_q, pl1_q, pr1_q;
  logic signed [ACC_W-1:0]    l0_q, r0_q, l1_q, r1_q;

  // Interpolation and rounding.
  logic signed [ACC_W:0]      dfl, dfr;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [DL_W-1:0]     dl_q, dr_q;
  logic signed [ACC_W-1:0]    bl_q, br_q;
  logic signed [SW-1:0]       suml, sumr, ql, qr;
  logic signed [15:0]         resl, resr, resl_q, resr_q;

  logic out_valid_q;
  logic out_free;

  wsr_mod #(.W(CW), .DIV(HISTORY_DEPTH)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.setup),
    .num_i   (d1),
    .busy_o  (mod_busy),
    .rem_o   (mod_rem)
  );

  // Window bounds for the output at the current position.
  always_comb begin
    ipos_x = CW'(pos_q[POS_W-1:FRAC_W]);
    seen_x = CW'(seen_q);
    d1     = (ipos_x >= HalfW) ? (ipos_x - HalfW) : '0;
    hi     = ipos_x + HalfW + 1'b1;
    d2     = (hi < seen_x) ? hi : seen_x;
    k_full = (d2 > d1 + 1'b1) ? (d2 - d1 - 1'b1) : '0;
    rem_init = (k_full == '0) ? '0 : TCW'(k_full + 1'b1);
    widx0  = (ipos_x >= HalfW) ? WIW'(1) : WIW'(HalfW + 1'b1 - ipos_x);
  end

  always_comb begin
    wp_nx    = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    raddr_cur = first_q ? mod_rem : raddr_q;
    raddr_nx = (raddr_cur == AW'(HISTORY_DEPTH - 1)) ? '0 : raddr_cur + 1'b1;
    issue    = !mod_busy && (rem_q != '0);
    hist_we  = cmd_i.wr_sample && (seen_q != CountMax);
    tot_prod = MUL_W'(seen_q) * MUL_W'(ratio_q) + MUL_W'(32768);
    pos_sum  = {1'b0, pos_q} + (POS_W + 1)'(step_q);
    pos_d    = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
    out_free = !out_valid_q || out_ready_i;
  end

  // Stream counters and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      ratio_q <= RATIO_RESET;
      pos_q   <= POS_W'(STEP_RESET >> 1);
      seen_q  <= '0;
      sent_q  <= '0;
      wp_q    <= '0;
      total_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_STEP) begin
          step_q <= cfg_data_i;
          if (seen_q == '0 && sent_q == '0) begin
            pos_q <= POS_W'(cfg_data_i >> 1);
          end
        end else if (cfg_index_i == REG_RATIO) begin
          ratio_q <= cfg_data_i[RATIO_W-1:0];
        end
      end
      if (hist_we) begin
        seen_q <= seen_q + 1'b1;
        wp_q   <= wp_nx;
      end
      if (cmd_i.calc_total) begin
        total_q <= tot_prod[MUL_W-1:16];
      end
      if (cmd_i.emit) begin
        sent_q <= sent_q + 1'b1;
        pos_q  <= pos_d;
      end
      if (cmd_i.restart) begin
        seen_q <= '0;
        sent_q <= '0;
        wp_q   <= '0;
        pos_q  <= POS_W'(step_q >> 1);
      end
    end
  end

  // Weight table: written by weight transfers, read one tap per cycle while the remainder unit is not busy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_weight && (weight_index_i < 7'(TAPS))) begin
      wtab_mem[weight_index_i[WIW-1:0]] <= weight_value_i;
    end
    if (issue) begin
      wq_q <= wtab_mem[widx_q];
    end
  end

  // Sample history ring: left in the low half, right in the high half.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[wp_q] <= {right_in_i, left_in_i};
    end
    if (issue) begin
      hq_q <= hist_mem[raddr_cur];
    end
  end

  // Tap sequencing. The first read only primes the previous-sample register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      first_q    <= 1'b0;
      s1_v_q     <= 1'b0;
      s1_first_q <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      s1_v_q     <= issue;
      s1_first_q <= first_q;
      s2_v_q     <= s1_v_q && !s1_first_q;
      if (cmd_i.setup) begin
        rem_q   <= rem_init;
        first_q <= 1'b1;
      end else if (issue) begin
        rem_q   <= rem_q - 1'b1;
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      widx_q <= widx0;
    end else if (issue) begin
      raddr_q <= raddr_nx;
      if (!first_q) begin
        widx_q <= widx_q + 1'b1;
      end
    end
    if (s1_v_q) begin
      prev_q <= hq_q;
      pl0_q  <= $signed(prev_q[SAMPLE_W-1:0]) * wq_q;
      pr0_q  <= $signed(prev_q[2*SAMPLE_W-1:SAMPLE_W]) * wq_q;
      pl1_q  <= $signed(hq_q[SAMPLE_W-1:0]) * wq_q;
      pr1_q  <= $signed(hq_q[2*SAMPLE_W-1:SAMPLE_W]) * wq_q;
    end
    if (cmd_i.setup) begin
      l0_q <= '0;
      r0_q <= '0;
      l1_q <= '0;
      r1_q <= '0;
    end else if (s2_v_q) begin
      l0_q <= l0_q + ACC_W'(pl0_q);
      r0_q <= r0_q + ACC_W'(pr0_q);
      l1_q <= l1_q + ACC_W'(pl1_q);
      r1_q <= r1_q + ACC_W'(pr1_q);
    end
  end

  // Linear interpolation between the two sums, then round and saturate to Q1.15.
  always_comb begin
    frac_s = $signed({1'b0, pos_q[FRAC_W-1:0]});
    dfl    = (ACC_W + 1)'(l1_q) - (ACC_W + 1)'(l0_q);
    dfr    = (ACC_W + 1)'(r1_q) - (ACC_W + 1)'(r0_q);
    suml   = (SW'(bl_q) <<< 16) + SW'(dl_q) + (SW'(1) <<< 32);
    sumr   = (SW'(br_q) <<< 16) + SW'(dr_q) + (SW'(1) <<< 32);
    ql     = suml >>> 33;
    qr     = sumr >>> 33;
    if (ql > SW'(32767)) begin
      resl = 16'sh7fff;
    end else if (ql < -SW'(32768)) begin
      resl = -16'sh8000;
    end else begin
      resl = ql[15:0];
    end
    if (qr > SW'(32767)) begin
      resr = 16'sh7fff;
    end else if (qr < -SW'(32768)) begin
      resr = -16'sh8000;
    end else begin
      resr = qr[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.interp) begin
      dl_q <= DL_W'(dfl) * DL_W'(frac_s);
      dr_q <= DL_W'(dfr) * DL_W'(frac_s);
      bl_q <= l0_q;
      br_q <= r0_q;
    end
    if (cmd_i.do_round) begin
      resl_q <= resl;
      resr_q <= resr;
    end
    if (cmd_i.emit) begin
      left_out_o   <= resl_q;
      right_out_o  <= resr_q;
      stream_end_o <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign st_o.busy       = mod_busy || (rem_q != '0) || s1_v_q || s2_v_q;
  assign st_o.norm_go    = (sent_q != CountMax) && (seen_x >= hi);
  assign st_o.flush_go   = (TOT_W'(sent_q) < total_q) && (sent_q != CountMax);
  assign st_o.more_after = (TOT_W'(sent_q) + 1'b1 < total_q) && (sent_q != CountMax - 1'b1);
  assign st_o.out_free   = out_free;

`ifndef SYNTH
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.emit))
    else $error("result register became valid without an emit");
  a_ring_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q == '0) |-> (wp_q == '0))
    else $error("history write pointer out of step with the sample count");
`endif

endmodule
`default_nettype wire

/* sv/wsr_ctrl.sv */
// Controller: sequences weight writes, sample intake, per-output MAC runs and the end-of-stream flush.
`default_nettype none
module wsr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic               final_sample_i,
  output wsr_pkg::cmd_t           cmd_o,
  input  wire wsr_pkg::status_t   st_i
);
  import wsr_pkg::*;

  localparam int NW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_TOTAL  = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_SETUP  = 8'b0000_1000,
    S_RUN    = 8'b0001_0000,
    S_INTERP = 8'b0010_0000,
    S_ROUND  = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic            flush_q, flush_d;
  logic [NW-1:0]   n_q, n_d;
  logic            accept;
  logic            go;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    flush_d = flush_q;
    n_d     = n_q;
    cmd_o   = '0;
    go      = (n_q < NW'(MAX_RESULTS)) && (flush_q ? st_i.flush_go : st_i.norm_go);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_WEIGHT) begin
            cmd_o.wr_weight = 1'b1;
          end else begin
            cmd_o.wr_sample = 1'b1;
            n_d     = '0;
            flush_d = final_sample_i;
            state_d = final_sample_i ? S_TOTAL : S_CHECK;
          end
        end
      end
      S_TOTAL: begin
        cmd_o.calc_total = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (go) begin
          state_d = S_SETUP;
        end else begin
          cmd_o.restart = flush_q;
          state_d = S_IDLE;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = S_RUN;
      end
      S_RUN: begin
        if (!st_i.busy) begin
          state_d = S_INTERP;
        end
      end
      S_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.do_round = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = flush_q && ((n_q == NW'(MAX_RESULTS - 1)) || !st_i.more_after);
          n_d     = n_q + 1'b1;
          state_d = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flush_q <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
      n_q     <= n_d;
    end
  end

`ifndef SYNTH
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !st_i.busy)
    else $error("tap pipeline still busy while accepting transfers");
  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_RESULTS))
    else $error("more results for one input than allowed");
`endif

endmodule
`default_nettype wire

/* sv/windowed_sinc_resampler_top.sv */
// Top level of the stereo windowed-sinc downsampling resampler.
// Sequencing: a weight transfer goes straight to the table; a sample that ends the stream
// first forms the output total; each result runs a MAC pass over the K taps in its window,
// interpolates and rounds, and waits while the result register is still held on the output.
// One item is processed at a time; the input is ready only while the controller is idle.
// Reset (asynchronous, active low) clears counters and resets control registers; memories are not cleared.
`default_nettype none
module windowed_sinc_resampler_top #(
  parameter int HALF_TAPS     = wsr_pkg::HALF_TAPS_DEF,
  parameter int HISTORY_DEPTH = wsr_pkg::HISTORY_DEPTH_DEF,
  parameter int COUNT_BITS    = wsr_pkg::COUNT_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wsr_in_if.sink     in_i,
  wsr_out_if.source  out_o,
  wsr_cfg_if.sink    cfg_i
);
  import wsr_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Register writes are always taken; the user must send them only while the block is idle (not enforced here).
  assign cfg_i.ready = 1'b1;

  wsr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .req_type_i     (in_i.req_type),
    .final_sample_i (in_i.final_sample),
    .cmd_o          (cmd),
    .st_i           (st)
  );

  wsr_datapath #(
    .HALF_TAPS     (HALF_TAPS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .weight_index_i (in_i.weight_index),
    .weight_value_i (in_i.weight_value),
    .left_in_i      (in_i.left_in),
    .right_in_i     (in_i.right_in),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .left_out_o     (out_o.left_out),
    .right_out_o    (out_o.right_out),
    .stream_end_o   (out_o.stream_end)
  );

endmodule
`default_nettype wire

/* dv/windowed_sinc_resampler_top_tb.sv */
// Self-checking testbench for the stereo windowed-sinc downsampling resampler.
`default_nettype none
module windowed_sinc_resampler_top_tb;
  import wsr_pkg::*;

  localparam int  TAP_CNT    = 2 * HALF_TAPS_DEF + 1;
  localparam int  HIST_CNT   = HISTORY_DEPTH_DEF;
  localparam longint unsigned POS_LIMIT = (64'd1 << POS_W) - 1;
  localparam longint unsigned CNT_LIMIT = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam int  DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic                       req_type;
    logic [WIDX_W-1:0]          weight_index;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       final_sample;
  } audio_req_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       stream_end;
  } audio_pair_t;

  logic clk_i;
  logic rst_ni;

  wsr_in_if  in_if();
  wsr_out_if out_if();
  wsr_cfg_if cfg_if();

  windowed_sinc_resampler_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  audio_req_t  pending_reqs[$];
  audio_pair_t expected_pairs[$];

  // Shadow state of the resampler.
  logic signed [WEIGHT_W-1:0] coef_tab[TAP_CNT];
  logic [31:0]                hist_ram[HIST_CNT];
  longint unsigned            seen_cnt, sent_cnt, out_pos, step_reg, ratio_reg;

  int  err_cnt, pair_cnt, sample_cnt, stream_cnt;
  bit  in_fire, quiet;
  int  in_gap, out_stall;
  longint cycle_cnt;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] round_q15(input longint acc);
    longint q;
    q = (acc + (64'sd1 <<< 32)) >>> 33;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic void restart_stream();
    seen_cnt = 0;
    sent_cnt = 0;
    out_pos  = step_reg >> 1;
  endfunction

  function automatic void interp_pair();
    longint ipos, frac, lo, hi, j, w, l0, l1, r0, r1;
    logic [31:0] a, b;
    audio_pair_t p;
    ipos = longint'(out_pos >> 16);
    frac = longint'(out_pos & 64'hFFFF);
    lo = ipos - HALF_TAPS_DEF;
    hi = ipos + HALF_TAPS_DEF + 1;
    l0 = 0; l1 = 0; r0 = 0; r1 = 0;
    if (lo < 0) lo = 0;
    if (hi > longint'(seen_cnt)) hi = longint'(seen_cnt);
    for (j = lo + 1; j < hi; j++) begin
      w = coef_tab[j - ipos + HALF_TAPS_DEF];
      a = hist_ram[(j - 1) % HIST_CNT];
      b = hist_ram[j % HIST_CNT];
      l0 += longint'($signed(a[15:0])) * w;
      r0 += longint'($signed(a[31:16])) * w;
      l1 += longint'($signed(b[15:0])) * w;
      r1 += longint'($signed(b[31:16])) * w;
    end
    p.left_out   = round_q15(l0 * 65536 + (l1 - l0) * frac);
    p.right_out  = round_q15(r0 * 65536 + (r1 - r0) * frac);
    p.stream_end = 1'b0;
    expected_pairs = {expected_pairs, p};
    sent_cnt++;
    out_pos = (out_pos + step_reg > POS_LIMIT) ? POS_LIMIT : out_pos + step_reg;
  endfunction

  function automatic void predict_pairs(input audio_req_t r);
    longint unsigned total;
    int n;
    n = 0;
    if (r.req_type == REQ_WEIGHT) begin
      if (r.weight_index < TAP_CNT) coef_tab[r.weight_index] = r.weight_value;
      return;
    end
    if (seen_cnt < CNT_LIMIT) begin
      hist_ram[seen_cnt % HIST_CNT] = {r.right_in, r.left_in};
      seen_cnt++;
    end
    if (r.final_sample) begin
      total = (seen_cnt * ratio_reg + 64'h8000) >> 16;
      while (sent_cnt < total && sent_cnt < CNT_LIMIT && n < MAX_RESULTS) begin
        interp_pair();
        n++;
      end
      if (n > 0) expected_pairs[$].stream_end = 1'b1;
      restart_stream();
    end else begin
      while (n < MAX_RESULTS && sent_cnt < CNT_LIMIT &&
             seen_cnt >= (out_pos >> 16) + HALF_TAPS_DEF + 1) begin
        interp_pair();
        n++;
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input driver: holds valid until the transfer, then inserts a random gap; also stalls output ready at random.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_if.valid        <= 1'b1;
        in_if.req_type     <= pending_reqs[0].req_type;
        in_if.weight_index <= pending_reqs[0].weight_index;
        in_if.weight_value <= pending_reqs[0].weight_value;
        in_if.left_in      <= pending_reqs[0].left_in;
        in_if.right_in     <= pending_reqs[0].right_in;
        in_if.final_sample <= pending_reqs[0].final_sample;
        void'(pending_reqs.pop_front());
        in_gap <= pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni;
      out_stall <= ($urandom_range(0, 9) == 0) ? pick_gap() : 0;
    end
  end

  // Monitor: checks result transfers and feeds accepted inputs to the predictor.
  always @(posedge clk_i) begin
    audio_req_t  r;
    audio_pair_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("windowed_sinc_resampler_top_tb: done, errors");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      pair_cnt++;
      if (expected_pairs.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = expected_pairs.pop_front();
        if (out_if.left_out !== e.left_out)
          report_mismatch($sformatf("left_out %0d, want %0d", out_if.left_out, e.left_out));
        if (out_if.right_out !== e.right_out)
          report_mismatch($sformatf("right_out %0d, want %0d", out_if.right_out, e.right_out));
        if (out_if.stream_end !== e.stream_end)
          report_mismatch($sformatf("stream_end %0b, want %0b", out_if.stream_end,
                                    e.stream_end));
      end
    end
    in_fire <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      r.req_type     = in_if.req_type;
      r.weight_index = in_if.weight_index;
      r.weight_value = in_if.weight_value;
      r.left_in      = in_if.left_in;
      r.right_in     = in_if.right_in;
      r.final_sample = in_if.final_sample;
      if (r.req_type == REQ_SAMPLE) sample_cnt++;
      if (r.req_type == REQ_SAMPLE && r.final_sample) stream_cnt++;
      predict_pairs(r);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == REG_STEP) begin
      step_reg = val & 64'h1FFFFF;
      if (seen_cnt == 0 && sent_cnt == 0) out_pos = step_reg >> 1;
    end else begin
      ratio_reg = val & 64'h1FFFF;
    end
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_if.valid || expected_pairs.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_weight(input int idx, input int val);
    audio_req_t r;
    r.req_type     = REQ_WEIGHT;
    r.weight_index = WIDX_W'(idx);
    r.weight_value = WEIGHT_W'(val);
    r.left_in      = SAMPLE_W'($urandom);
    r.right_in     = SAMPLE_W'($urandom);
    r.final_sample = 1'($urandom_range(0, 1));
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic queue_sample(input int l, input int rr, input bit fin);
    audio_req_t r;
    r.req_type     = REQ_SAMPLE;
    r.weight_index = WIDX_W'($urandom);
    r.weight_value = WEIGHT_W'($urandom);
    r.left_in      = SAMPLE_W'(l);
    r.right_in     = SAMPLE_W'(rr);
    r.final_sample = fin;
    pending_reqs = {pending_reqs, r};
  endtask

  // Loads a full table; wide weights drive the sums into saturation.
  task automatic load_weights(input bit wide);
    for (int i = 0; i < TAP_CNT; i++)
      queue_weight(i, wide ? int'($urandom) : $urandom_range(0, 8191) - 4096);
  endtask

  // One stream: mostly random samples, an occasional weight rewrite or stray index.
  task automatic random_stream(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) queue_weight($urandom_range(0, 127),
                                                   $urandom_range(0, 8191) - 4096);
      if ($urandom_range(0, 3) == 0)
        queue_sample($urandom_range(0, 1) ? 32767 : -32768, $urandom, k == n - 1);
      else
        queue_sample($urandom, $urandom, k == n - 1);
    end
  endtask

  task automatic set_rates(input longint unsigned s, input longint unsigned q);
    wait_idle();
    write_reg(REG_STEP, s);
    write_reg(REG_RATIO, q);
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0; in_if.req_type = REQ_WEIGHT; in_if.weight_index = '0;
    in_if.weight_value = '0; in_if.left_in = '0; in_if.right_in = '0;
    in_if.final_sample = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = REG_STEP; cfg_if.data = '0;
    in_fire = 0; in_gap = 0; out_stall = 0; quiet = 0; cycle_cnt = 0;
    err_cnt = 0; pair_cnt = 0; sample_cnt = 0; stream_cnt = 0;
    foreach (coef_tab[i]) coef_tab[i] = '0;
    foreach (hist_ram[i]) hist_ram[i] = '0;
    step_reg = STEP_RESET;
    ratio_reg = RATIO_RESET;
    restart_stream();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: weight extremes, ignored indexes, sample extremes at unity rate.
    set_rates(65536, 65536);
    load_weights(1'b0);
    queue_weight(1, 131071);
    queue_weight(64, -131072);
    queue_weight(65, 1000);
    queue_weight(127, -1000);
    queue_sample(32767, -32768, 0);
    queue_sample(-32768, 32767, 0);
    queue_sample(32767, 32767, 0);
    queue_sample(-32768, -32768, 0);
    queue_sample(0, -1, 1);

    // A single sample whose rounded output total is zero: no result at all.
    set_rates(65536, 4096);
    queue_sample(1234, -4321, 1);

    // Coarsest step, unity ratio: the flush hits the per-item result cap.
    set_rates(1048576, 65536);
    random_stream(42);

    // One short stream at random rates.
    set_rates($urandom_range(65536, 1048576), $urandom_range(4096, 65536));
    random_stream($urandom_range(8, 14));

    wait_idle();
    $display("covered %0d streams, %0d samples, %0d checked results", stream_cnt,
             sample_cnt, pair_cnt);
    $display("step and ratio at their extremes and at random, full-scale taps at both ends");
    if (err_cnt == 0) begin
      $display("windowed_sinc_resampler_top_tb: done, clean");
    end else begin
      $display("windowed_sinc_resampler_top_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
sv/wsr_pkg.sv
sv/wsr_if.sv
sv/wsr_mod.sv
sv/wsr_datapath.sv
sv/wsr_ctrl.sv
sv/windowed_sinc_resampler_top.sv
dv/windowed_sinc_resampler_top_tb.sv
